/* src/three_axis_position_pid_defines.svh */
// Assertion macros used by the controller's top-level RTL file.
`ifndef THREE_AXIS_POSITION_PID_DEFINES_SVH
`define THREE_AXIS_POSITION_PID_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define TAPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The property must hold at every clock edge, reset included.
`define TAPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/tapp_pkg.sv */
`default_nettype none
package tapp_pkg;
  localparam int unsigned ErrW = 33;
  localparam int unsigned SumW = 48;
  localparam int unsigned DrvW = 17;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned SettleBand = 10;
  localparam int unsigned CoarseBand = 500;

  localparam logic [2:0] RegProp = 3'd0;
  localparam logic [2:0] RegInteg = 3'd1;
  localparam logic [2:0] RegDeriv = 3'd2;
  localparam logic [2:0] RegFine = 3'd3;
  localparam logic [2:0] RegCoarse = 3'd4;

  localparam logic [1:0] ModeSettled = 2'd0;
  localparam logic [1:0] ModeCoarse = 2'd1;
  localparam logic [1:0] ModeFine = 2'd2;

  typedef struct packed {
    logic signed [15:0] prop;
    logic signed [15:0] integ;
    logic signed [15:0] deriv;
    logic [15:0] fine_lim;
  } gains_t;
endpackage
`default_nettype wire

/* src/tapp_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle: quot = low 16 bits of num / den.
module tapp_div import tapp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [15:0]      quot
);
  logic [47:0] q;
  logic [32:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {r[31:0], q[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        r <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          r <= trial;
          q <= {q[46:0], 1'b1};
        end else begin
          r <= {r[31:0], q[47]};
          q <= {q[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quot = q[15:0];
endmodule
`default_nettype wire

/* src/tapp_lane.sv */
`default_nettype none
// One axis: error state, settled zero drive, stepped fine PID, coarse ratio divider.
module tapp_lane import tapp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [1:0]             mode,
  input  wire logic                   clr_sum,
  input  wire logic signed [ErrW-1:0] err,
  input  wire logic                   is_big,
  input  wire logic [15:0]            cap,
  input  wire logic [31:0]            big_mag,
  input  wire gains_t                 gains,
  output logic                        done,
  output logic signed [DrvW-1:0]      drive
);
  logic signed [ErrW-1:0] last_error;
  logic signed [SumW-1:0] error_sum;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic [2:0] step;
  logic signed [ErrW:0] diff;
  logic signed [SumW:0] sum_ext;
  logic signed [63:0] lim_hi;
  logic signed [63:0] quo;
  logic [32:0] amag;
  logic [47:0] dnum;
  logic div_start;
  logic div_done;
  logic [15:0] quot;
  logic neg;
  logic [15:0] mag_sel;

  assign diff = {err[ErrW-1], err} - {last_error[ErrW-1], last_error};
  assign sum_ext = {error_sum[SumW-1], error_sum} + {{16{err[ErrW-1]}}, err};
  assign lim_hi = {40'd0, gains.fine_lim, 8'd0};
  assign quo = (acc < 0) ? -((-acc) >>> 8) : (acc >>> 8);
  assign amag = err[ErrW-1] ? -err : err;
  assign dnum = 48'(cap) * 48'(amag[31:0]);
  assign neg = err[ErrW-1];
  assign mag_sel = is_big ? cap : quot;

  tapp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(big_mag),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum <= '0;
      step <= '0;
      done <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done <= 1'b0;
      div_start <= 1'b0;
      if (start) begin
        if (clr_sum) error_sum <= '0;
        if (mode == ModeSettled) begin
          drive <= '0;
          done <= 1'b1;
        end else if (mode == ModeCoarse) begin
          if (is_big) begin
            drive <= neg ? -DrvW'(mag_sel) : DrvW'(mag_sel);
            done <= 1'b1;
          end else begin
            div_start <= 1'b1;
            step <= 3'd7;
          end
        end else begin
          acc <= '0;
          step <= 3'd1;
        end
      end else if (step == 3'd7) begin
        if (div_done) begin
          drive <= neg ? -DrvW'(quot) : DrvW'(quot);
          done <= 1'b1;
          step <= '0;
        end
      end else if (step != 3'd0) begin
        step <= (step == 3'd5) ? 3'd0 : step + 3'd1;
        case (step)
          3'd1: prod <= 64'(gains.prop) * 64'(err);
          3'd2: begin
            acc <= acc + prod;
            prod <= 64'(gains.integ) * 64'(error_sum);
          end
          3'd3: begin
            acc <= acc + prod;
            prod <= 64'(gains.deriv) * 64'(diff);
          end
          3'd4: acc <= acc + prod;
          3'd5: begin
            if (acc > lim_hi) drive <= DrvW'({1'b0, gains.fine_lim});
            else if (acc < -lim_hi) drive <= -DrvW'({1'b0, gains.fine_lim});
            else drive <= DrvW'(quo);
            last_error <= err;
            if (sum_ext > (SumW+1)'(64'sh7FFF_FFFF_FFFF)) error_sum <= 48'h7FFF_FFFF_FFFF;
            else if (sum_ext < -(SumW+1)'(64'sh8000_0000_0000))
              error_sum <= 48'h8000_0000_0000;
            else error_sum <= sum_ext[SumW-1:0];
            done <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* src/three_axis_position_pid.sv */
// Settled, fine PID and coarse ticks take different paths; coarse ticks wait on the
// 48-step restoring divider in each lane but the one of the largest-error axis.
// Throughput: one tick at a time; the next is taken once the result is held.
// A held result does not block input, but the next result moves out only once it is taken.
// Reset (rst, synchronous, active high) restores gains and limits and clears lane error history.
`default_nettype none
module three_axis_position_pid import tapp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] goal_a,
  input  wire logic signed [31:0] goal_b,
  input  wire logic signed [31:0] goal_c,
  input  wire logic signed [31:0] count_a,
  input  wire logic signed [31:0] count_b,
  input  wire logic signed [31:0] count_c,
  input  wire logic               new_goal,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      drive_a,
  output logic signed [16:0]      drive_b,
  output logic signed [16:0]      drive_c,
  output logic [1:0]              mode
);
  `include "three_axis_position_pid_defines.svh"

  gains_t gains;
  logic [15:0] coarse_lim;
  logic busy;
  logic started;
  logic signed [ErrW-1:0] err [NumAxes];
  logic [32:0] amag [NumAxes];
  logic [1:0] cur_mode;
  logic clr;
  logic [15:0] cap;
  logic [1:0] big;
  logic [NumAxes-1:0] ldone;
  logic [NumAxes-1:0] got;
  logic signed [DrvW-1:0] ldrv [NumAxes];
  logic [34:0] cap_raw;
  logic accept;
  logic finish;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign accept = in_valid && !in_stall;
  // The lanes hold their drives, so the result moves to the outputs only once they are free.
  assign finish = busy && ((got | ldone) == '1) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop <= 16'sd256;
      gains.integ <= '0;
      gains.deriv <= '0;
      gains.fine_lim <= 16'd1000;
      coarse_lim <= 16'd3000;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegProp: gains.prop <= cfg_data;
        RegInteg: gains.integ <= cfg_data;
        RegDeriv: gains.deriv <= cfg_data;
        RegFine: gains.fine_lim <= cfg_data;
        RegCoarse: coarse_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NumAxes; i++) amag[i] = err[i][ErrW-1] ? -err[i] : err[i];
    if (amag[0] <= 33'(SettleBand) && amag[1] <= 33'(SettleBand)
        && amag[2] <= 33'(SettleBand)) cur_mode = ModeSettled;
    else if (amag[0] > 33'(CoarseBand) && amag[1] > 33'(CoarseBand)
        && amag[2] > 33'(CoarseBand)) cur_mode = ModeCoarse;
    else cur_mode = ModeFine;
    cap_raw = (35'(amag[1]) * 35'd7) >> 1;
    cap = (cap_raw > 35'(coarse_lim)) ? coarse_lim : cap_raw[15:0];
    if (amag[0] >= amag[1] && amag[0] >= amag[2]) big = 2'd0;
    else if (amag[1] >= amag[2]) big = 2'd1;
    else big = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      started <= 1'b0;
      out_valid <= 1'b0;
      got <= '0;
    end else begin
      started <= accept;
      if (finish) begin
        out_valid <= 1'b1;
        drive_a <= ldrv[0];
        drive_b <= ldrv[1];
        drive_c <= ldrv[2];
        mode <= cur_mode;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        clr <= new_goal;
        err[0] <= 33'(goal_a) - 33'(count_a);
        err[1] <= 33'(goal_b) - 33'(count_b);
        err[2] <= 33'(goal_c) - 33'(count_c);
        got <= '0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy) begin
        got <= got | ldone;
      end
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    tapp_lane u_lane (
      .clk(clk), .rst(rst), .start(started), .mode(cur_mode), .clr_sum(clr),
      .err(err[g]), .is_big(big == 2'(g)), .cap(cap), .big_mag(amag[big][31:0]),
      .gains(gains), .done(ldone[g]), .drive(ldrv[g])
    );
  end

  `TAPP_ASSERT(a_no_accept_busy, busy |-> !accept, "item accepted while busy")
  `TAPP_ASSERT(a_mode_range, out_valid |-> mode != 2'd3, "bad mode code")
  `TAPP_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !busy, "not idle after reset")
endmodule
`default_nettype wire
